>>> hw/rtl/rhsv_pkg.sv
// rhsv_pkg: shared types and constants for the rgb to hsv pipeline
// used by rhsv_front, rhsv_div_stage and rgb_to_hsv_converter
package rhsv_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned HUE_W    = 15;
   localparam int unsigned SAT_W    = 13;
   // quotient bits produced by the divider stages, and bits per stage
   localparam int unsigned DIV_BITS = 12;
   localparam int unsigned DIV_STEP = 4;
   localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEP;

   localparam logic [HUE_W-1:0] HUE_BASE_RED   = 15'd0;
   localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 15'd15360;
   localparam logic [HUE_W:0]   HUE_TURN       = 16'd23040;
   localparam logic [3:0]       HUE_SECTOR_DIV256 = 4'd15;  // 3840 = 15 * 256

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // side information that travels along the divider stages
   typedef struct packed {
      logic [CHAN_W-1:0] value;
      logic              grey;
      sector_type        sector;
      logic              neg;
      logic              sat_msb;
   } side_type;

   // partial state of one restoring divider
   typedef struct packed {
      logic [CHAN_W-1:0]   rem;
      logic [CHAN_W-1:0]   den;
      logic [DIV_BITS-1:0] num;
      logic [DIV_BITS-1:0] quot;
   } div_type;

endpackage

>>> hw/rtl/rhsv_front.sv
// rhsv_front: first two pipeline stages, channel sort and divider setup
// depends on rhsv_pkg
module rhsv_front (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rhsv_pkg::CHAN_W-1:0] red,
   input  logic [rhsv_pkg::CHAN_W-1:0] green,
   input  logic [rhsv_pkg::CHAN_W-1:0] blue,
   output rhsv_pkg::side_type          side_o,
   output rhsv_pkg::div_type           sat_o,
   output rhsv_pkg::div_type           hue_o
);
   import rhsv_pkg::*;

   logic [CHAN_W-1:0] mx, mn, p, q;
   sector_type        sector;

   logic [CHAN_W-1:0] value_ff, value_in;
   logic [CHAN_W-1:0] delta_ff, delta_in;
   logic [CHAN_W-1:0] mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic              grey_ff, grey_in;
   sector_type        sector_ff, sector_in;

   side_type          side_ff, side_in;
   div_type           sat_ff, sat_in;
   div_type           hue_ff, hue_in;

   logic [11:0]       prod;
   logic              sat_ge;

   // stage one: largest, smallest, sector and signed difference
   always_comb begin
      mx = (red > green) ? red : green;
      if (blue > mx) mx = blue;
      mn = (red < green) ? red : green;
      if (blue < mn) mn = blue;
      priority if (red >= mx) begin
         sector = SECTOR_RED;
         p = green;
         q = blue;
      end else if (green >= mx) begin
         sector = SECTOR_GREEN;
         p = blue;
         q = red;
      end else begin
         sector = SECTOR_BLUE;
         p = red;
         q = green;
      end
      value_in  = mx;
      delta_in  = mx - mn;
      neg_in    = (p < q);
      mag_in    = (p < q) ? (q - p) : (p - q);
      grey_in   = (mx == mn);
      sector_in = sector;
   end

   // stage two: seed both dividers
   always_comb begin
      prod   = {4'd0, mag_ff} * {8'd0, HUE_SECTOR_DIV256};
      sat_ge = (delta_ff >= value_ff);

      side_in.value   = value_ff;
      side_in.grey    = grey_ff;
      side_in.sector  = sector_ff;
      side_in.neg     = neg_ff;
      side_in.sat_msb = sat_ge;

      sat_in.rem  = sat_ge ? (delta_ff - value_ff) : delta_ff;
      sat_in.den  = value_ff;
      sat_in.num  = '0;
      sat_in.quot = '0;

      // numerator 3840*mag, top bits seed the remainder (quotient fits 12 bits)
      hue_in.rem  = prod[11:4];
      hue_in.den  = delta_ff;
      hue_in.num  = {prod[3:0], 8'd0};
      hue_in.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff  <= value_in;
         delta_ff  <= delta_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         grey_ff   <= grey_in;
         sector_ff <= sector_in;
         side_ff   <= side_in;
         sat_ff    <= sat_in;
         hue_ff    <= hue_in;
      end
   end

   assign side_o = side_ff;
   assign sat_o  = sat_ff;
   assign hue_o  = hue_ff;

endmodule

>>> hw/rtl/rhsv_div_stage.sv
// rhsv_div_stage: one registered stage of a restoring divider, DIV_STEP bits
// depends on rhsv_pkg
module rhsv_div_stage (
   input  logic              clock,
   input  logic              en,
   input  rhsv_pkg::div_type div_i,
   output rhsv_pkg::div_type div_o
);
   import rhsv_pkg::*;

   div_type div_ff, div_in;

   always_comb begin
      logic [CHAN_W:0] trial;
      logic            qbit;
      div_in = div_i;
      for (int k = 0; k < DIV_STEP; k++) begin
         trial = {div_in.rem, div_in.num[DIV_BITS-1]};
         qbit  = (trial >= {1'b0, div_in.den});
         div_in.rem  = qbit ? CHAN_W'(trial - {1'b0, div_in.den}) : trial[CHAN_W-1:0];
         div_in.num  = {div_in.num[DIV_BITS-2:0], 1'b0};
         div_in.quot = {div_in.quot[DIV_BITS-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign div_o = div_ff;

endmodule

>>> hw/rtl/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: top level, front stages, divider chain and hue wrap
// depends on rhsv_pkg, rhsv_front, rhsv_div_stage
//
// Converts one 8-bit RGB pixel per clock into hue (1/64 degree), saturation
// (4096 = 1.0), value and a grey flag. The pipeline is six register stages
// deep; a new pixel can be taken every cycle while the output side does not
// stall. The depth is set by the two restoring dividers (saturation and hue
// offset), which retire four quotient bits per stage over three stages. A
// stall on the result side holds the whole pipeline, and req_ready is low
// only while a finished result waits to be taken.
module rgb_to_hsv_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rhsv_pkg::CHAN_W-1:0] req_red,
   input  logic [rhsv_pkg::CHAN_W-1:0] req_green,
   input  logic [rhsv_pkg::CHAN_W-1:0] req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rhsv_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rhsv_pkg::SAT_W-1:0]  rsp_saturation,
   output logic [rhsv_pkg::CHAN_W-1:0] rsp_value,
   output logic                        rsp_grey
);
   import rhsv_pkg::*;

   localparam int unsigned STAGES = DIV_STAGES + 3;

   logic              stage_en;
   logic [STAGES-1:0] valid_ff, valid_in;

   side_type side_chain [DIV_STAGES+1];
   div_type  sat_chain  [DIV_STAGES+1];
   div_type  hue_chain  [DIV_STAGES+1];

   logic [HUE_W-1:0]  base;
   logic [HUE_W:0]    hue_sum;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [SAT_W-1:0]  sat_ff, sat_in;
   logic [CHAN_W-1:0] value_ff, value_in;
   logic              grey_ff, grey_in;

   // whole pipeline moves together unless a result is held
   assign stage_en  = !valid_ff[STAGES-1] || rsp_ready;
   assign req_ready = stage_en;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   rhsv_front u_front (
      .clock  (clock),
      .en     (stage_en),
      .red    (req_red),
      .green  (req_green),
      .blue   (req_blue),
      .side_o (side_chain[0]),
      .sat_o  (sat_chain[0]),
      .hue_o  (hue_chain[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      side_type side_ff;

      rhsv_div_stage u_sat_div (
         .clock (clock),
         .en    (stage_en),
         .div_i (sat_chain[s]),
         .div_o (sat_chain[s+1])
      );

      rhsv_div_stage u_hue_div (
         .clock (clock),
         .en    (stage_en),
         .div_i (hue_chain[s]),
         .div_o (hue_chain[s+1])
      );

      always_ff @(posedge clock) begin
         if (stage_en) begin
            side_ff <= side_chain[s];
         end
      end

      assign side_chain[s+1] = side_ff;
   end

   // output stage: sector base, signed offset and wrap into one turn
   always_comb begin
      unique case (side_chain[DIV_STAGES].sector)
         SECTOR_RED:   base = HUE_BASE_RED;
         SECTOR_GREEN: base = HUE_BASE_GREEN;
         SECTOR_BLUE:  base = HUE_BASE_BLUE;
         default:      base = HUE_BASE_RED;
      endcase
      if (side_chain[DIV_STAGES].neg) begin
         hue_sum = {1'b0, base} - {4'd0, hue_chain[DIV_STAGES].quot};
      end else begin
         hue_sum = {1'b0, base} + {4'd0, hue_chain[DIV_STAGES].quot};
      end
      // top bit set means the sum went below zero
      if (hue_sum[HUE_W]) begin
         hue_sum = hue_sum + HUE_TURN;
      end
      grey_in  = side_chain[DIV_STAGES].grey;
      value_in = side_chain[DIV_STAGES].value;
      hue_in   = grey_in ? '0 : hue_sum[HUE_W-1:0];
      sat_in   = grey_in ? '0 : {side_chain[DIV_STAGES].sat_msb, sat_chain[DIV_STAGES].quot};
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= value_in;
         grey_ff  <= grey_in;
      end
   end

   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_value      = value_ff;
   assign rsp_grey       = grey_ff;

   // a held pipeline keeps every valid bit in place
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> valid_ff == $past(valid_ff))
      else $error("valid bits moved during a stall");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_hue} < HUE_TURN)
      else $error("hue outside one turn");

   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grey |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("grey transaction with nonzero hue or saturation");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grey |-> rsp_saturation != '0 && rsp_saturation <= 13'd4096)
      else $error("saturation out of range");

endmodule

>>> sim/tb.sv
// tb: self-checking testbench for rgb_to_hsv_converter
// depends on rhsv_pkg (port widths) and the rgb_to_hsv_converter rtl
// directed pixel table first, then random bursts checked against an integer hsv predictor
module tb;
   import rhsv_pkg::*;

   localparam int RANDOM_PIXELS = 1130;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;
   localparam int N_DIRECTED    = 24;

   // fixed point scale of the hsv result
   localparam int HUE_PER_SECTOR = 3840;
   localparam int HUE_GREEN_BASE = 7680;
   localparam int HUE_BLUE_BASE  = 15360;
   localparam int HUE_FULL_TURN  = 23040;
   localparam int SAT_UNITY      = 4096;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] value;
      logic              grey;
   } hsv_pixel_type;

   // one stimulus row; typed rows carry their result, others use the predictor
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              typed;
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] value;
      logic              grey;
   } pixel_row_type;

   typedef enum {
      PIX_UNIFORM,
      PIX_GREY,
      PIX_NEAR_GREY,
      PIX_TIED_MAX,
      PIX_EXTREME
   } pixel_kind_type;

   typedef enum {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red;
   logic [CHAN_W-1:0] req_green;
   logic [CHAN_W-1:0] req_blue;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [HUE_W-1:0]  rsp_hue;
   logic [SAT_W-1:0]  rsp_saturation;
   logic [CHAN_W-1:0] rsp_value;
   logic              rsp_grey;

   // expectation that travels with the payload of a typed row
   logic              cur_typed;
   hsv_pixel_type     cur_hsv;

   hsv_pixel_type     hsv_expected[$];
   int                mismatches     = 0;
   int                pixels_taken   = 0;
   int                results_seen   = 0;
   int                grey_results   = 0;
   int                stall_cycles   = 0;
   int                cycle_count    = 0;

   stall_mode_type    stall_mode     = STALL_NONE;
   int                stall_left     = 0;
   int                stall_phase    = 0;

   pixel_row_type directed_pixels [N_DIRECTED] = '{
      '{0,   0,   0,   1, 0,     0,    0,   1},
      '{255, 255, 255, 1, 0,     0,    255, 1},
      '{128, 128, 128, 1, 0,     0,    128, 1},
      '{1,   1,   1,   1, 0,     0,    1,   1},
      '{255, 0,   0,   1, 0,     4096, 255, 0},
      '{0,   255, 0,   1, 7680,  4096, 255, 0},
      '{0,   0,   255, 1, 15360, 4096, 255, 0},
      '{255, 255, 0,   1, 3840,  4096, 255, 0},
      '{0,   255, 255, 1, 11520, 4096, 255, 0},
      '{255, 0,   255, 1, 19200, 4096, 255, 0},
      '{1,   0,   0,   1, 0,     4096, 1,   0},
      '{255, 254, 254, 1, 0,     16,   255, 0},
      '{200, 100, 150, 0, 0,     0,    0,   0},
      '{100, 200, 150, 0, 0,     0,    0,   0},
      '{150, 100, 200, 0, 0,     0,    0,   0},
      '{255, 255, 254, 0, 0,     0,    0,   0},
      '{254, 255, 255, 0, 0,     0,    0,   0},
      '{255, 254, 255, 0, 0,     0,    0,   0},
      '{255, 0,   1,   0, 0,     0,    0,   0},
      '{1,   0,   255, 0, 0,     0,    0,   0},
      '{0,   1,   255, 0, 0,     0,    0,   0},
      '{170, 85,  0,   0, 0,     0,    0,   0},
      '{12,  34,  56,  0, 0,     0,    0,   0},
      '{254, 1,   128, 0, 0,     0,    0,   0}
   };

   rgb_to_hsv_converter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value),
      .rsp_grey       (rsp_grey)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic hsv_pixel_type rgb_to_hsv(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
      int            hi;
      int            lo;
      int            delta;
      int            angle;
      hsv_pixel_type res;
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = hi - lo;
      res = '0;
      res.value = hi[CHAN_W-1:0];
      if (delta == 0) begin
         res.grey = 1'b1;
      end else begin
         res.saturation = SAT_W'((SAT_UNITY * delta) / hi);
         // signed int division truncates toward zero
         if (r == hi) begin
            angle = (HUE_PER_SECTOR * (int'(g) - int'(b))) / delta;
         end else if (g == hi) begin
            angle = HUE_GREEN_BASE + (HUE_PER_SECTOR * (int'(b) - int'(r))) / delta;
         end else begin
            angle = HUE_BLUE_BASE + (HUE_PER_SECTOR * (int'(r) - int'(g))) / delta;
         end
         if (angle < 0) begin
            angle = angle + HUE_FULL_TURN;
         end
         res.hue = HUE_W'(angle);
      end
      return res;
   endfunction

   function automatic pixel_row_type random_pixel();
      pixel_row_type  row;
      pixel_kind_type kind;
      int             pick;
      int             top;
      int             base;
      pick = $urandom_range(0, 9);
      case (pick)
         5: kind = PIX_GREY;
         6: kind = PIX_NEAR_GREY;
         7: kind = PIX_TIED_MAX;
         8: kind = PIX_EXTREME;
         default: kind = PIX_UNIFORM;
      endcase
      row = '0;
      case (kind)
         PIX_GREY: begin
            row.red   = CHAN_W'($urandom_range(0, 255));
            row.green = row.red;
            row.blue  = row.red;
         end
         PIX_NEAR_GREY: begin
            base = $urandom_range(0, 252);
            row.red   = CHAN_W'(base + $urandom_range(0, 3));
            row.green = CHAN_W'(base + $urandom_range(0, 3));
            row.blue  = CHAN_W'(base + $urandom_range(0, 3));
         end
         PIX_TIED_MAX: begin
            top = $urandom_range(1, 255);
            base = $urandom_range(0, top - 1);
            row.red   = CHAN_W'(top);
            row.green = CHAN_W'(top);
            row.blue  = CHAN_W'(top);
            case ($urandom_range(0, 2))
               0: row.red   = CHAN_W'(base);
               1: row.green = CHAN_W'(base);
               default: row.blue = CHAN_W'(base);
            endcase
         end
         PIX_EXTREME: begin
            row.red   = extreme_byte();
            row.green = extreme_byte();
            row.blue  = extreme_byte();
         end
         default: begin
            row.red   = CHAN_W'($urandom());
            row.green = CHAN_W'($urandom());
            row.blue  = CHAN_W'($urandom());
         end
      endcase
      return row;
   endfunction

   function automatic logic [CHAN_W-1:0] extreme_byte();
      logic [CHAN_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = 8'd0;
         1: v = 8'd1;
         2: v = 8'd254;
         3: v = 8'd255;
         default: v = CHAN_W'($urandom());
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch at cycle %0d result %0d: %s got %0d want %0d",
                  cycle_count, results_seen, what, got, want);
      end
   endtask

   // holds the pixel until a transaction completes on the request side
   task automatic send_pixel(input pixel_row_type row);
      @(negedge clock);
      req_valid <= 1'b1;
      req_red   <= row.red;
      req_green <= row.green;
      req_blue  <= row.blue;
      cur_typed <= row.typed;
      cur_hsv   <= '{row.hue, row.saturation, row.value, row.grey};
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // receiver stall pattern, switching to a randomly chosen mode when the current one runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_mode <= STALL_NONE;
            1: stall_mode <= STALL_COIN;
            2: stall_mode <= STALL_SPARSE;
            default: stall_mode <= STALL_PERIODIC;
         endcase
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= (stall_phase + 1) % 7;
      case (stall_mode)
         STALL_NONE:     rsp_ready <= 1'b1;
         STALL_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE:   rsp_ready <= ($urandom_range(0, 4) == 0);
         STALL_PERIODIC: rsp_ready <= (stall_phase < 3);
         default:        rsp_ready <= 1'b1;
      endcase
   end

   // results are checked before new pixels are queued, in one process
   always @(posedge clock) begin
      hsv_pixel_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, hsv_expected.size());
         $display("FAIL rgb_to_hsv_converter");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_ready) begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (rsp_grey) begin
               grey_results <= grey_results + 1;
            end
            if (hsv_expected.size() == 0) begin
               report_mismatch("unexpected result, hue", rsp_hue, -1);
            end else begin
               want = hsv_expected.pop_front();
               if (rsp_hue != want.hue) begin
                  report_mismatch("hue", rsp_hue, want.hue);
               end
               if (rsp_saturation != want.saturation) begin
                  report_mismatch("saturation", rsp_saturation, want.saturation);
               end
               if (rsp_value != want.value) begin
                  report_mismatch("value", rsp_value, want.value);
               end
               if (rsp_grey != want.grey) begin
                  report_mismatch("grey", rsp_grey, want.grey);
               end
            end
         end
         if (req_valid && req_ready) begin
            pixels_taken <= pixels_taken + 1;
            if (cur_typed) begin
               hsv_expected.push_back(cur_hsv);
            end else begin
               hsv_expected.push_back(rgb_to_hsv(req_red, req_green, req_blue));
            end
         end
      end
   end

   initial begin
      int            burst_left;
      int            n;
      pixel_row_type row;
      req_valid = 1'b0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      cur_typed = 1'b0;
      cur_hsv   = '0;
      reset     = 1'b1;
      burst_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < N_DIRECTED; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 4));
         end
         send_pixel(directed_pixels[n]);
      end

      for (n = 0; n < RANDOM_PIXELS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // some bursts follow straight on with no gap
            if ($urandom_range(0, 3) != 0) begin
               idle_sender($urandom_range(1, 12));
            end
         end
         row = random_pixel();
         send_pixel(row);
         burst_left--;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (hsv_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d pixels into %0d results (%0d grey), directed table of %0d rows",
               pixels_taken, results_seen, grey_results, N_DIRECTED);
      $display("receiver held off %0d result cycles over %0d cycles, %0d mismatches",
               stall_cycles, cycle_count, mismatches);
      if (mismatches == 0) begin
         $display("PASS rgb_to_hsv_converter");
      end else begin
         $display("FAIL rgb_to_hsv_converter");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_front.sv
hw/rtl/rhsv_div_stage.sv
hw/rtl/rgb_to_hsv_converter.sv
sim/tb.sv
